@@ hdl/ibp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// IEC 61937 burst packer package
// Shared types, codes and helper functions for the burst packer front part,
// command queue, back part and top level.
// ----------------------------------------------------------------------------
package ibp_pkg;

   localparam int HEAD_HOLD = 6;
   localparam int CMD_WORDS = 7;

   localparam logic [15:0] MIN_BURST_WORDS = 16'd8;
   localparam logic [15:0] MAX_BURST_WORDS = 16'd32768;

   localparam logic [15:0] SYNC_PA   = 16'hF872;
   localparam logic [15:0] SYNC_PB   = 16'h4E1F;
   localparam logic [15:0] PD_TRUEHD = 16'd61424;
   localparam logic [15:0] HD_ROUND  = 16'h0017;
   localparam logic [15:0] HD_MASK   = 16'hFFF0;
   localparam logic [15:0] HD_TRIM   = 16'h0008;
   localparam logic [2:0]  BSMOD_MASK = 3'h7;

   localparam logic [2:0] FMT_AC3   = 3'd0;
   localparam logic [2:0] FMT_EAC3  = 3'd1;
   localparam logic [2:0] FMT_DTS   = 3'd2;
   localparam logic [2:0] FMT_TRUEHD = 3'd3;
   localparam logic [2:0] FMT_DTSHD = 3'd4;

   localparam logic [2:0] REG_FORMAT      = 3'd0;
   localparam logic [2:0] REG_BURST_WORDS = 3'd1;
   localparam logic [2:0] REG_TYPE_CODE   = 3'd2;
   localparam logic [2:0] REG_HD_PERIOD   = 3'd3;
   localparam logic [2:0] REG_DTS_LE      = 3'd4;

   typedef enum logic [2:0] {
      MODE_PACKED  = 3'b001,
      MODE_RAW     = 3'b010,
      MODE_DISCARD = 3'b100
   } mode_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [15:0] frame_bytes;
   } req_type;

   typedef struct packed {
      logic [15:0] word;
      logic [15:0] fill_words;
      logic        error;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  format;
      logic [15:0] burst_words;
      logic [4:0]  type_code;
      logic [14:0] hd_period;
      logic        dts_little_endian;
   } cfg_type;

   typedef struct packed {
      logic                         err;
      logic [2:0]                   nwords;
      logic [CMD_WORDS-1:0][15:0]   words;
      logic [15:0]                  fill;
   } cmd_type;

   function automatic logic [15:0] pair(input logic [7:0] a, input logic [7:0] b,
                                        input logic swap);
      logic [15:0] w;
      if (swap) begin
         w = {b, a};
      end else begin
         w = {a, b};
      end
      return w;
   endfunction

   // Returns the valid flag in bit 3 and the subtype in the low three bits.
   function automatic logic [3:0] hd_subtype(input logic [14:0] period);
      logic [3:0] r;
      case (period)
         15'd512: begin
            r = {1'b1, 3'd0};
         end
         15'd1024: begin
            r = {1'b1, 3'd1};
         end
         15'd2048: begin
            r = {1'b1, 3'd2};
         end
         15'd4096: begin
            r = {1'b1, 3'd3};
         end
         15'd8192: begin
            r = {1'b1, 3'd4};
         end
         15'd16384: begin
            r = {1'b1, 3'd5};
         end
         default: begin
            r = 4'd0;
         end
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

@@ hdl/ibp_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Burst packer command queue
// Two-entry queue of burst commands between the front and back parts.
// ----------------------------------------------------------------------------
module ibp_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire ibp_pkg::cmd_type cmd_in,
   input  wire logic             pop,
   output ibp_pkg::cmd_type      head,
   output logic                  not_empty,
   output logic                  full
);

   ibp_pkg::cmd_type ent_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign head      = ent_ff[rd_ptr_ff];
   assign not_empty = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("Command pushed into a full queue.");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && !not_empty))
      else $error("Command popped from an empty queue.");

endmodule
`default_nettype wire

@@ hdl/ibp_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Burst packer front part
// Accepts frame bytes, tracks framing, classifies each frame and turns the
// bytes into burst commands of header words, payload words, fill or error.
// ----------------------------------------------------------------------------
module ibp_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ibp_pkg::cfg_type cfg,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire ibp_pkg::req_type req_payload,
   input  wire logic             q_full,
   output logic                  q_push,
   output ibp_pkg::cmd_type      q_cmd
);

   logic [15:0]       byte_count_ff, byte_count_in;
   ibp_pkg::mode_type frame_mode_ff, frame_mode_in;
   logic [7:0]        odd_byte_ff, odd_byte_in;
   logic [7:0]        head_ff [ibp_pkg::HEAD_HOLD-1];

   logic              accept;
   logic [7:0]        b;
   logic [15:0]       fb;
   logic [15:0]       idx;
   logic              zero_len, first, eof, head_phase, swap, bad, has_out;
   logic [3:0]        st;
   logic [15:0]       burst_len;
   logic [16:0]       burst_bytes;
   ibp_pkg::mode_type new_mode, mode;
   logic [7:0]        hb [ibp_pkg::HEAD_HOLD];
   logic [15:0]       pc, pd;
   logic [16:0]       used, total;
   logic [15:0]       fill;
   logic [3:0]        nwords_hdr;
   ibp_pkg::cmd_type  cmd;

   assign b         = req_payload.data_byte;
   assign fb        = req_payload.frame_bytes;
   assign idx       = byte_count_ff;
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   always_comb begin
      zero_len = (fb == 16'd0);
      first    = (idx == 16'd0);
      eof      = ({1'b0, idx} + 17'd1) >= {1'b0, fb};
      st       = ibp_pkg::hd_subtype(cfg.hd_period);
      swap     = (cfg.format == ibp_pkg::FMT_DTS) && cfg.dts_little_endian;
      bad      = (cfg.format > ibp_pkg::FMT_DTSHD) ||
                 ((cfg.format == ibp_pkg::FMT_DTSHD) && !st[3]);

      if (cfg.format == ibp_pkg::FMT_DTSHD) begin
         burst_len = {cfg.hd_period, 1'b0};
      end else if (cfg.burst_words < ibp_pkg::MIN_BURST_WORDS) begin
         burst_len = ibp_pkg::MIN_BURST_WORDS;
      end else if (cfg.burst_words > ibp_pkg::MAX_BURST_WORDS) begin
         burst_len = ibp_pkg::MAX_BURST_WORDS;
      end else begin
         burst_len = cfg.burst_words;
      end
      burst_bytes = {burst_len, 1'b0};

      if (!bad && (cfg.format == ibp_pkg::FMT_DTS) && ({1'b0, fb} == burst_bytes)) begin
         new_mode = ibp_pkg::MODE_RAW;
      end else if (bad || ({1'b0, fb} > (burst_bytes - 17'd8))) begin
         new_mode = ibp_pkg::MODE_DISCARD;
      end else begin
         new_mode = ibp_pkg::MODE_PACKED;
      end
      mode = first ? new_mode : frame_mode_ff;

      head_phase = (mode == ibp_pkg::MODE_PACKED) &&
                   (idx < 16'(ibp_pkg::HEAD_HOLD));

      for (int i = 0; i < ibp_pkg::HEAD_HOLD - 1; i++) begin
         hb[i] = (idx[2:0] == 3'(i)) ? b : head_ff[i];
      end
      hb[ibp_pkg::HEAD_HOLD-1] = b;

      pc = {11'd0, cfg.type_code};
      case (cfg.format)
         ibp_pkg::FMT_AC3: begin
            if (idx[2:0] == 3'(ibp_pkg::HEAD_HOLD - 1)) begin
               pc[10:8] = b[2:0] & ibp_pkg::BSMOD_MASK;
            end
            pd = {fb[12:0], 3'd0};
         end
         ibp_pkg::FMT_EAC3: begin
            pd = fb;
         end
         ibp_pkg::FMT_DTS: begin
            pd = {fb[12:0], 3'd0};
         end
         ibp_pkg::FMT_TRUEHD: begin
            pd = ibp_pkg::PD_TRUEHD;
         end
         default: begin
            pc[10:8] = st[2:0];
            pd = ((fb + ibp_pkg::HD_ROUND) & ibp_pkg::HD_MASK) - ibp_pkg::HD_TRIM;
         end
      endcase

      used  = 17'd4 + (({1'b0, idx} + 17'd2) >> 1);
      total = {1'b0, burst_len};
      fill  = (total > used) ? 16'(total - used) : 16'd0;

      nwords_hdr = 4'd4 + ((4'({1'b0, idx[2:0]}) + 4'd2) >> 1);

      cmd     = '0;
      has_out = 1'b0;
      if (zero_len) begin
         cmd.err = 1'b1;
         has_out = 1'b1;
      end else if (mode == ibp_pkg::MODE_DISCARD) begin
         if (first) begin
            cmd.err = 1'b1;
            has_out = 1'b1;
         end
      end else if (!head_phase) begin
         if (idx[0]) begin
            cmd.words[0] = ibp_pkg::pair(odd_byte_ff, b, swap);
            cmd.nwords   = 3'd1;
            has_out      = 1'b1;
         end else if (eof) begin
            cmd.words[0] = ibp_pkg::pair(b, 8'd0, swap);
            cmd.nwords   = 3'd1;
            has_out      = 1'b1;
         end
      end else if ((idx[2:0] == 3'(ibp_pkg::HEAD_HOLD - 1)) || eof) begin
         cmd.words[0] = ibp_pkg::SYNC_PA;
         cmd.words[1] = ibp_pkg::SYNC_PB;
         cmd.words[2] = pc;
         cmd.words[3] = pd;
         for (int k = 0; k < 3; k++) begin
            cmd.words[4+k] = ibp_pkg::pair(hb[2*k],
               (idx[2:0] >= 3'(2*k + 1)) ? hb[2*k+1] : 8'd0, swap);
         end
         cmd.nwords = nwords_hdr[2:0];
         has_out    = 1'b1;
      end
      if (!zero_len && eof && (mode == ibp_pkg::MODE_PACKED)) begin
         cmd.fill = fill;
      end

      q_cmd  = cmd;
      q_push = accept && has_out;

      byte_count_in = byte_count_ff;
      frame_mode_in = frame_mode_ff;
      odd_byte_in   = odd_byte_ff;
      if (accept) begin
         if (zero_len || eof) begin
            byte_count_in = 16'd0;
            frame_mode_in = ibp_pkg::MODE_PACKED;
         end else begin
            byte_count_in = idx + 16'd1;
            frame_mode_in = mode;
         end
         if (!zero_len && (mode != ibp_pkg::MODE_DISCARD) && !head_phase && !idx[0]) begin
            odd_byte_in = b;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= 16'd0;
         frame_mode_ff <= ibp_pkg::MODE_PACKED;
         odd_byte_ff   <= 8'd0;
      end else begin
         byte_count_ff <= byte_count_in;
         frame_mode_ff <= frame_mode_in;
         odd_byte_ff   <= odd_byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !zero_len && head_phase &&
          (idx[2:0] < 3'(ibp_pkg::HEAD_HOLD - 1))) begin
         head_ff[idx[2:0]] <= b;
      end
   end

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      (frame_mode_ff == ibp_pkg::MODE_DISCARD) |-> (byte_count_ff != 16'd0))
      else $error("Discarding a frame with no bytes counted.");

endmodule
`default_nettype wire

@@ hdl/ibp_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Burst packer back part
// Walks the command at the head of the queue and issues its result items one
// per cycle into the output register while that register is free.
// ----------------------------------------------------------------------------
module ibp_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ibp_pkg::cmd_type head,
   input  wire logic             q_valid,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output ibp_pkg::rsp_type      rsp_payload
);

   logic [2:0]       pos_ff, pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   ibp_pkg::rsp_type rsp_ff, rsp_in;

   ibp_pkg::rsp_type res;
   logic             done, out_free, take;
   logic [3:0]       pos_ext, nw_ext;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      pos_ext = {1'b0, pos_ff};
      nw_ext  = {1'b0, head.nwords};
      res     = '0;
      done    = 1'b0;
      if (head.err) begin
         res.error = 1'b1;
         res.last  = 1'b1;
         done      = 1'b1;
      end else if (pos_ext < nw_ext) begin
         res.word = head.words[pos_ff];
         if (((pos_ext + 4'd1) == nw_ext) && (head.fill == 16'd0)) begin
            res.last = 1'b1;
            done     = 1'b1;
         end
      end else begin
         res.fill_words = head.fill;
         res.last       = 1'b1;
         done           = 1'b1;
      end

      out_free = !rsp_valid_ff || !rsp_stall;
      take     = out_free && q_valid;
      q_pop    = take && done;

      if (q_pop) begin
         pos_in = 3'd0;
      end else if (take) begin
         pos_in = pos_ff + 3'd1;
      end else begin
         pos_in = pos_ff;
      end

      rsp_valid_in = take ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);
      rsp_in       = take ? res : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   a_error_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.error) |->
         (rsp_ff.last && (rsp_ff.word == 16'd0) && (rsp_ff.fill_words == 16'd0)))
      else $error("Error result is not a lone final result.");

   a_pos_restarts: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (pos_ff == 3'd0))
      else $error("Word position not restarted after a command completed.");

endmodule
`default_nettype wire

@@ hdl/iec61937_burst_packer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// IEC 61937 burst packer
// Packs compressed-audio frame bytes into IEC 61937 burst words.
//
// Bytes arrive on the req_ channel with the frame length alongside; each
// transfer takes one byte. Result items leave on the rsp_ channel: burst
// words, one item standing for a run of zero fill words, or an error item
// for a rejected frame. The csr_ port holds format, burst length, data type,
// DTS-HD period and the DTS byte order; write it only while the block is idle.
// The front part classifies each byte in the cycle of its transfer and puts
// any command into a two-entry queue; the back part issues one result per
// cycle while the output is free; a byte's first result passes the queue
// entry, then the output register. A completed word is one item, a header up
// to seven, a frame end a fill item; input takes one byte per cycle while
// the queue has room. When the receiver stalls, the output register holds
// its result, the queue fills and req_stall rises after two commands wait.
// Reset restarts framing and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module iec61937_burst_packer (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire ibp_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output ibp_pkg::rsp_type      rsp_payload,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [4:0]       csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   ibp_pkg::cfg_type cfg_ff, cfg_in;
   logic             csr_wr;
   logic [2:0]       csr_idx;

   logic             q_push, q_pop, q_valid, q_full;
   ibp_pkg::cmd_type q_cmd, q_head;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_idx)
            ibp_pkg::REG_FORMAT: begin
               cfg_in.format = csr_pwdata[2:0];
            end
            ibp_pkg::REG_BURST_WORDS: begin
               cfg_in.burst_words = csr_pwdata[15:0];
            end
            ibp_pkg::REG_TYPE_CODE: begin
               cfg_in.type_code = csr_pwdata[4:0];
            end
            ibp_pkg::REG_HD_PERIOD: begin
               cfg_in.hd_period = csr_pwdata[14:0];
            end
            ibp_pkg::REG_DTS_LE: begin
               cfg_in.dts_little_endian = csr_pwdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         ibp_pkg::REG_FORMAT: begin
            csr_prdata = {29'd0, cfg_ff.format};
         end
         ibp_pkg::REG_BURST_WORDS: begin
            csr_prdata = {16'd0, cfg_ff.burst_words};
         end
         ibp_pkg::REG_TYPE_CODE: begin
            csr_prdata = {27'd0, cfg_ff.type_code};
         end
         ibp_pkg::REG_HD_PERIOD: begin
            csr_prdata = {17'd0, cfg_ff.hd_period};
         end
         ibp_pkg::REG_DTS_LE: begin
            csr_prdata = {31'd0, cfg_ff.dts_little_endian};
         end
         default: begin
            csr_prdata = 32'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.format            <= ibp_pkg::FMT_AC3;
         cfg_ff.burst_words       <= 16'd3072;
         cfg_ff.type_code         <= 5'd1;
         cfg_ff.hd_period         <= 15'd512;
         cfg_ff.dts_little_endian <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ibp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_cmd       (q_cmd)
   );

   ibp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .cmd_in    (q_cmd),
      .pop       (q_pop),
      .head      (q_head),
      .not_empty (q_valid),
      .full      (q_full)
   );

   ibp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (q_head),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire
